>>> rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/mdbp_pkg.sv
package mdbp_pkg;

    // Configuration port geometry: six 64-bit registers at 8-byte spacing.
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // Register indexes.
    localparam logic [2:0] REG_CLASS_LABEL    = 3'd0;
    localparam logic [2:0] REG_OPTICAL_CENTER = 3'd1;
    localparam logic [2:0] REG_INVERSE_FOCAL  = 3'd2;
    localparam logic [2:0] REG_POSE_ROW_X     = 3'd3;
    localparam logic [2:0] REG_POSE_ROW_Y     = 3'd4;
    localparam logic [2:0] REG_POSE_ROW_Z     = 3'd5;

    // Accepted depth window in Q4.12 metres (0.01 m to 10 m inclusive).
    localparam logic [15:0] DEPTH_MIN_Q = 16'd41;
    localparam logic [15:0] DEPTH_MAX_Q = 16'd40960;

    // One input pixel.
    typedef struct packed {
        logic [9:0]  column;
        logic [9:0]  row;
        logic [7:0]  label;
        logic [15:0] depth_q;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
    } pixel_t;

    // One output point.
    typedef struct packed {
        logic               point_valid;
        logic               mask_overwrite;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [7:0]         blue_out;
        logic [7:0]         green_out;
        logic [7:0]         red_out;
    } point_t;

    // Decoded configuration handed from the register file to the datapath.
    // rot[k][j] multiplies camera coordinate j for world row k.
    typedef struct packed {
        logic [7:0]             class_label;
        logic [15:0]            cx;
        logic [15:0]            cy;
        logic [23:0]            inv_fx;
        logic [23:0]            inv_fy;
        logic [2:0][2:0][15:0]  rot;
        logic [2:0][15:0]       trans;
    } cfg_t;

endpackage

>>> rtl/mdbp_regs.sv
module mdbp_regs
    import mdbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [7:0]  class_label_reg;
    logic [31:0] optical_center_reg;
    logic [47:0] inverse_focal_reg;
    logic [63:0] pose_reg [3];
    logic [2:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:3];
    assign wr_en     = psel && penable && pwrite;

    // Register writes happen in the access phase of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_label_reg    <= '0;
            optical_center_reg <= '0;
            inverse_focal_reg  <= '0;
            pose_reg[0]        <= '0;
            pose_reg[1]        <= '0;
            pose_reg[2]        <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_CLASS_LABEL:    class_label_reg    <= pwdata[7:0];
                REG_OPTICAL_CENTER: optical_center_reg <= pwdata[31:0];
                REG_INVERSE_FOCAL:  inverse_focal_reg  <= pwdata[47:0];
                REG_POSE_ROW_X:     pose_reg[0]        <= pwdata;
                REG_POSE_ROW_Y:     pose_reg[1]        <= pwdata;
                REG_POSE_ROW_Z:     pose_reg[2]        <= pwdata;
                default:            ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_index)
            REG_CLASS_LABEL:    prdata = 64'(class_label_reg);
            REG_OPTICAL_CENTER: prdata = 64'(optical_center_reg);
            REG_INVERSE_FOCAL:  prdata = 64'(inverse_focal_reg);
            REG_POSE_ROW_X:     prdata = pose_reg[0];
            REG_POSE_ROW_Y:     prdata = pose_reg[1];
            REG_POSE_ROW_Z:     prdata = pose_reg[2];
            default:            prdata = '0;
        endcase
    end

    // Field decode for the datapath.
    always_comb
    begin
        cfg.class_label = class_label_reg;
        cfg.cx          = optical_center_reg[15:0];
        cfg.cy          = optical_center_reg[31:16];
        cfg.inv_fx      = inverse_focal_reg[23:0];
        cfg.inv_fy      = inverse_focal_reg[47:24];
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cfg.rot[k][j] = pose_reg[k][16*j +: 16];
            end
            cfg.trans[k] = pose_reg[k][63:48];
        end
    end

endmodule

>>> rtl/masked_depth_backprojection_unit.sv
// Masked depth back-projection unit.
// Pixels arrive on the pixel channel (valid/ready), one beat per pixel, and
// each pixel yields exactly one beat on the result channel, in order. A pixel
// outside the frame or with a foreign label gives an all-zero result; a
// matching pixel sets mask_overwrite, and also point_valid with world
// coordinates and colour when its depth lies in the accepted window.
// Throughput is one pixel per cycle while the result channel does not stall;
// an accepted pixel beat passes the seven-stage multiply pipeline (offsets,
// depth product, split reciprocal product, rounding, rotation products, sum,
// saturation), whose last stage is the output register.
// A stalled receiver holds the output register; stages behind it keep filling
// until every stage holds a beat, and only then does pixel_ready fall.
// The configuration registers sit on an APB port at 8-byte spacing and are to
// be written only while the pipeline is empty.
// Reset clears the configuration registers and all stage valid bits, so the
// block comes out of reset empty and ready for pixels.
module masked_depth_backprojection_unit
    import mdbp_pkg::*;
#(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  pixel_t            pixel,
    output logic              result_valid,
    input  logic              result_ready,
    output point_t            result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int NSTG = 7;
    localparam logic [9:0] FRAME_W = 10'(FRAME_WIDTH);
    localparam logic [9:0] FRAME_H = 10'(FRAME_HEIGHT);
    localparam logic signed [59:0] RND_CAM   = 60'sh0000000_00800000;
    localparam logic signed [54:0] RND_WORLD = 55'sh2000;

    typedef struct packed {
        logic       keep;
        logic       mask;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } side_t;

    cfg_t cfg;

    mdbp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage valid bits and per-stage load enables.
    logic [NSTG:1] v_reg;
    logic [NSTG:1] en;

    always_comb
    begin
        en[NSTG] = !v_reg[NSTG] || result_ready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign pixel_ready  = en[1];
    assign result_valid = v_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= pixel_valid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: classify the pixel and form the offsets from the optical centre.
    logic               in_frame;
    logic               label_match;
    logic               depth_ok;
    side_t              side_next;
    logic signed [17:0] dd_next [2];

    always_comb
    begin
        in_frame    = (pixel.column < FRAME_W) && (pixel.row < FRAME_H);
        label_match = pixel.label == cfg.class_label;
        depth_ok    = (pixel.depth_q >= DEPTH_MIN_Q) && (pixel.depth_q <= DEPTH_MAX_Q);
        side_next.mask  = in_frame && label_match;
        side_next.keep  = in_frame && label_match && depth_ok;
        side_next.blue  = pixel.blue_in;
        side_next.green = pixel.green_in;
        side_next.red   = pixel.red_in;
        dd_next[0] = $signed({4'd0, pixel.column, 4'd0}) - $signed({2'd0, cfg.cx});
        dd_next[1] = $signed({4'd0, pixel.row, 4'd0}) - $signed({2'd0, cfg.cy});
    end

    // Stage 2: offset times depth.
    side_t              side_reg [1:NSTG-1];
    logic signed [17:0] dd_reg [2];
    logic [15:0]        depth1_reg;
    logic [15:0]        depth2_reg;
    logic [15:0]        depth3_reg;
    logic signed [34:0] pd_next [2];
    logic signed [34:0] pd_reg [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            pd_next[i] = dd_reg[i] * $signed({1'b0, depth1_reg});
        end
    end

    // Stage 3: depth product times the reciprocal focal length, in two halves.
    logic [23:0]        inv_f [2];
    logic signed [47:0] lo_next [2];
    logic signed [47:0] hi_next [2];
    logic signed [47:0] lo_reg [2];
    logic signed [47:0] hi_reg [2];

    assign inv_f[0] = cfg.inv_fx;
    assign inv_f[1] = cfg.inv_fy;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            lo_next[i] = pd_reg[i] * $signed({1'b0, inv_f[i][11:0]});
            hi_next[i] = pd_reg[i] * $signed({1'b0, inv_f[i][23:12]});
        end
    end

    // Stage 4: recombine the halves and round to Q.16 camera coordinates.
    logic signed [59:0] full [2];
    logic signed [35:0] pc_next [3];
    logic signed [35:0] pc_reg [3];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            full[i]    = (60'(hi_reg[i]) <<< 12) + 60'(lo_reg[i]) + RND_CAM;
            pc_next[i] = full[i][59:24];
        end
        pc_next[2] = 36'({depth3_reg, 4'd0});
    end

    // Stage 5: the nine rotation products.
    logic signed [51:0] prod_next [3][3];
    logic signed [51:0] prod_reg [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[k][j] = $signed(cfg.rot[k][j]) * pc_reg[j];
            end
        end
    end

    // Stage 6: sum each row with its translation and the rounding constant.
    logic signed [54:0] acc_next [3];
    logic signed [54:0] acc_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_next[k] = 55'(prod_reg[k][0]) + 55'(prod_reg[k][1]) + 55'(prod_reg[k][2])
                        + (55'($signed(cfg.trans[k])) <<< 22) + RND_WORLD;
        end
    end

    // Stage 7: scale to Q16.16, saturate and blank the fields of non-points.
    logic signed [40:0] shifted [3];
    logic signed [31:0] sat [3];
    side_t              last_side;
    point_t             result_next;
    point_t             result_reg;

    assign last_side = side_reg[NSTG-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            shifted[k] = acc_reg[k][54:14];
            if (shifted[k][40:31] == '0 || shifted[k][40:31] == '1)
            begin
                sat[k] = shifted[k][31:0];
            end
            else if (shifted[k][40])
            begin
                sat[k] = 32'sh8000_0000;
            end
            else
            begin
                sat[k] = 32'sh7FFF_FFFF;
            end
        end
        result_next.point_valid    = last_side.keep;
        result_next.mask_overwrite = last_side.mask;
        result_next.world_x   = last_side.keep ? sat[0] : '0;
        result_next.world_y   = last_side.keep ? sat[1] : '0;
        result_next.world_z   = last_side.keep ? sat[2] : '0;
        result_next.blue_out  = last_side.keep ? last_side.blue : '0;
        result_next.green_out = last_side.keep ? last_side.green : '0;
        result_next.red_out   = last_side.keep ? last_side.red : '0;
    end

    assign result = result_reg;

    // Datapath registers; each stage loads when it may advance.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg[1] <= side_next;
            dd_reg      <= dd_next;
            depth1_reg  <= pixel.depth_q;
        end
        for (int k = 2; k <= NSTG - 1; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (en[2])
        begin
            pd_reg     <= pd_next;
            depth2_reg <= depth1_reg;
        end
        if (en[3])
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            depth3_reg <= depth2_reg;
        end
        if (en[4])
        begin
            pc_reg <= pc_next;
        end
        if (en[5])
        begin
            prod_reg <= prod_next;
        end
        if (en[6])
        begin
            acc_reg <= acc_next;
        end
        if (en[7])
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> rtl/mdbp_checker.sv
`include "assert_macros.svh"

module mdbp_checker
    import mdbp_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pixel_ready,
    input logic   result_valid,
    input logic   result_ready,
    input point_t result
);

    logic out_stall;
    logic fields_zero;

    // Shorthand terms used by the properties below.
    assign out_stall   = result_valid && !result_ready;
    assign fields_zero = (result.world_x == '0) && (result.world_y == '0)
                      && (result.world_z == '0) && (result.blue_out == '0)
                      && (result.green_out == '0) && (result.red_out == '0);

    // A stalled result beat stays put.
    `ASSERT_NEXT(a_result_hold, clk, rst_n, out_stall, result_valid && $stable(result))

    // A point is only ever produced for a pixel that also overwrites the mask.
    `ASSERT_IMPLIES(a_point_has_mask, clk, rst_n, result_valid && result.point_valid, result.mask_overwrite)

    // Beats without a point carry zero coordinates and colour.
    `ASSERT_IMPLIES(a_no_point_zero, clk, rst_n, result_valid && !result.point_valid, fields_zero)

    // With the output register empty the whole pipeline can advance.
    `ASSERT_IMPLIES(a_ready_when_drained, clk, rst_n, !result_valid, pixel_ready)

    // Back-pressure on the pixel channel only ever comes from a stalled result beat.
    `ASSERT_IMPLIES(a_stall_source, clk, rst_n, !pixel_ready, out_stall)

endmodule

bind masked_depth_backprojection_unit mdbp_checker u_mdbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mdbp_pkg::*;

    localparam int FRAME_W = 640;
    localparam int FRAME_H = 480;

    // Bounds of a signed Q16.16 coordinate.
    localparam longint Q16_MAX = 64'sh7FFFFFFF;
    localparam longint Q16_MIN = -64'sh80000000;

    // A directed probe: one pixel, plus the outcome typed in where it is obvious.
    // With the pose still at its reset value of zero, every kept point lands at
    // the world origin and carries its colour through.
    typedef struct packed {
        logic [9:0]  column;
        logic [9:0]  row;
        logic [7:0]  label;
        logic [15:0] depth_q;
        logic [23:0] bgr;
        logic        typed;
        logic        want_point;
        logic        want_mask;
    } probe_t;

    localparam int NUM_PROBES = 18;
    localparam probe_t DIRECTED_PROBES [NUM_PROBES] = '{
        '{10'd0,    10'd0,    8'd0,   16'd41,    24'hFFFFFF, 1'b1, 1'b1, 1'b1},
        '{10'd639,  10'd479,  8'd0,   16'd40960, 24'h000000, 1'b1, 1'b1, 1'b1},
        '{10'd640,  10'd0,    8'd0,   16'd1000,  24'h5A5A5A, 1'b1, 1'b0, 1'b0},
        '{10'd0,    10'd480,  8'd0,   16'd1000,  24'hA5A5A5, 1'b1, 1'b0, 1'b0},
        '{10'd1023, 10'd1023, 8'd255, 16'd65535, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
        '{10'd639,  10'd480,  8'd0,   16'd2000,  24'h010203, 1'b1, 1'b0, 1'b0},
        '{10'd10,   10'd10,   8'd1,   16'd1000,  24'h112233, 1'b1, 1'b0, 1'b0},
        '{10'd10,   10'd10,   8'd255, 16'd1000,  24'h445566, 1'b1, 1'b0, 1'b0},
        '{10'd5,    10'd5,    8'd0,   16'd40,    24'h778899, 1'b1, 1'b0, 1'b1},
        '{10'd5,    10'd5,    8'd0,   16'd0,     24'hAABBCC, 1'b1, 1'b0, 1'b1},
        '{10'd5,    10'd5,    8'd0,   16'd40961, 24'hDDEEFF, 1'b1, 1'b0, 1'b1},
        '{10'd5,    10'd5,    8'd0,   16'd65535, 24'hFFFFFF, 1'b1, 1'b0, 1'b1},
        '{10'd1023, 10'd5,    8'd0,   16'd41,    24'h0F0F0F, 1'b1, 1'b0, 1'b0},
        '{10'd320,  10'd240,  8'd0,   16'd4096,  24'h123456, 1'b0, 1'b0, 1'b0},
        '{10'd512,  10'd256,  8'd0,   16'd32768, 24'hA5C3F0, 1'b0, 1'b0, 1'b0},
        '{10'd1,    10'd479,  8'd0,   16'd20000, 24'h3C3C3C, 1'b0, 1'b0, 1'b0},
        '{10'd638,  10'd1,    8'd0,   16'd40959, 24'hF00F55, 1'b1, 1'b1, 1'b1},
        '{10'd0,    10'd479,  8'd0,   16'd42,    24'h00FF00, 1'b1, 1'b1, 1'b1}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              pixel_valid = 1'b0;
    logic              pixel_ready;
    pixel_t            pixel = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    point_t            result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow copy of the camera configuration, as last written.
    logic [7:0]  cam_class = '0;
    logic [31:0] cam_center = '0;
    logic [47:0] cam_inv_focal = '0;
    logic [63:0] cam_pose [3] = '{64'd0, 64'd0, 64'd0};

    point_t      pending_points [$];
    int unsigned mismatches = 0;
    int unsigned pixels_sent = 0;
    int unsigned points_taken = 0;

    masked_depth_backprojection_unit #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Half-up rounding: floor(v / 2^s + 1/2).
    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clamp_q16(longint v);
        if (v > Q16_MAX)
            return 32'h7FFF_FFFF;
        if (v < Q16_MIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Packs one transform row: rotation entries then translation.
    function automatic logic [63:0] pose_word(int r0, int r1, int r2, int t);
        return {16'(t), 16'(r2), 16'(r1), 16'(r0)};
    endfunction

    // Back-projects one pixel into world space under the shadow configuration.
    function automatic point_t project_pixel(pixel_t px);
        point_t      pt;
        longint      du;
        longint      dv;
        longint      depth;
        longint      cam [3];
        longint      acc;
        logic [63:0] pose;
        logic [31:0] world [3];
        pt = '0;
        if (px.column >= FRAME_W || px.row >= FRAME_H || px.label != cam_class)
            return pt;
        pt.mask_overwrite = 1'b1;
        if (px.depth_q < DEPTH_MIN_Q || px.depth_q > DEPTH_MAX_Q)
            return pt;

        // Camera frame: offsets in 1/16 pixel, scaled by depth and 1/f.
        depth = longint'(px.depth_q);
        du = longint'(px.column) * 16 - longint'(cam_center[15:0]);
        dv = longint'(px.row) * 16 - longint'(cam_center[31:16]);
        cam[0] = round_half_up(du * depth * longint'(cam_inv_focal[23:0]), 24);
        cam[1] = round_half_up(dv * depth * longint'(cam_inv_focal[47:24]), 24);
        cam[2] = depth * 16;

        // Rigid transform into world space, one row per axis.
        for (int k = 0; k < 3; k++)
        begin
            pose = cam_pose[k];
            acc = longint'($signed(pose[15:0])) * cam[0]
                + longint'($signed(pose[31:16])) * cam[1]
                + longint'($signed(pose[47:32])) * cam[2]
                + longint'($signed(pose[63:48])) * (longint'(1) <<< 22);
            world[k] = clamp_q16(round_half_up(acc, 14));
        end

        pt.point_valid = 1'b1;
        pt.world_x = world[0];
        pt.world_y = world[1];
        pt.world_z = world[2];
        pt.blue_out = px.blue_in;
        pt.green_out = px.green_in;
        pt.red_out = px.red_in;
        return pt;
    endfunction

    // Register write over the configuration port, mirrored into the shadow.
    task automatic write_register(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CLASS_LABEL:    cam_class = value[7:0];
            REG_OPTICAL_CENTER: cam_center = value[31:0];
            REG_INVERSE_FOCAL:  cam_inv_focal = value[47:0];
            REG_POSE_ROW_X:     cam_pose[0] = value;
            REG_POSE_ROW_Y:     cam_pose[1] = value;
            REG_POSE_ROW_Z:     cam_pose[2] = value;
            default:            ;
        endcase
    endtask

    // Offers one pixel beat after an optional gap; queues its point on acceptance.
    task automatic send_pixel(pixel_t px, point_t want);
        int unsigned gap;
        gap = ((pixels_sent % 64) < 20) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (!pixel_ready);
        pending_points = {pending_points, want};
        pixels_sent++;
    endtask

    // Random pixels, mostly in frame, on the class and at a usable depth.
    task automatic stream_pixels(int count);
        pixel_t      px;
        int unsigned pick;
        for (int n = 0; n < count; n++)
        begin
            px.column = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, FRAME_W - 1))
                                                    : 10'($urandom_range(FRAME_W, 1023));
            px.row = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, FRAME_H - 1))
                                                 : 10'($urandom_range(FRAME_H, 1023));
            px.label = ($urandom_range(0, 99) < 80) ? cam_class : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 75)
                px.depth_q = 16'($urandom_range(DEPTH_MIN_Q, DEPTH_MAX_Q));
            else if (pick < 85)
            begin
                case ($urandom_range(0, 3))
                    0:       px.depth_q = DEPTH_MIN_Q - 16'd1;
                    1:       px.depth_q = DEPTH_MIN_Q;
                    2:       px.depth_q = DEPTH_MAX_Q;
                    default: px.depth_q = DEPTH_MAX_Q + 16'd1;
                endcase
            end
            else
                px.depth_q = 16'($urandom_range(0, 65535));
            px.blue_in = 8'($urandom);
            px.green_in = 8'($urandom);
            px.red_in = 8'($urandom);
            send_pixel(px, project_pixel(px));
        end
        pixel_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus two long hold-offs that back up the pipeline.
    initial
    begin
        point_t      got;
        point_t      want;
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (points_taken == 60 || points_taken == 300)
                stall = 80;
            else if ((points_taken % 80) < 25)
                stall = 0;
            else
                stall = $urandom_range(0, 11);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            got = result;
            points_taken++;

            // Compare against the oldest outstanding point.
            if (pending_points.size() == 0)
            begin
                $error("result beat with no pixel outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (got.point_valid !== want.point_valid)
                begin
                    $error("point_valid: expected %0d, got %0d", want.point_valid,
                           got.point_valid);
                    mismatches++;
                end
                if (got.mask_overwrite !== want.mask_overwrite)
                begin
                    $error("mask_overwrite: expected %0d, got %0d", want.mask_overwrite,
                           got.mask_overwrite);
                    mismatches++;
                end
                if (got.world_x !== want.world_x)
                begin
                    $error("world_x: expected %0d, got %0d", $signed(want.world_x),
                           $signed(got.world_x));
                    mismatches++;
                end
                if (got.world_y !== want.world_y)
                begin
                    $error("world_y: expected %0d, got %0d", $signed(want.world_y),
                           $signed(got.world_y));
                    mismatches++;
                end
                if (got.world_z !== want.world_z)
                begin
                    $error("world_z: expected %0d, got %0d", $signed(want.world_z),
                           $signed(got.world_z));
                    mismatches++;
                end
                if (got.blue_out !== want.blue_out)
                begin
                    $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
                    mismatches++;
                end
                if (got.green_out !== want.green_out)
                begin
                    $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
                    mismatches++;
                end
                if (got.red_out !== want.red_out)
                begin
                    $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed probes, then configured random phases.
    initial
    begin
        probe_t pr;
        pixel_t px;
        point_t want;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes under the reset configuration.
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            pr = DIRECTED_PROBES[i];
            px.column = pr.column;
            px.row = pr.row;
            px.label = pr.label;
            px.depth_q = pr.depth_q;
            px.blue_in = pr.bgr[23:16];
            px.green_in = pr.bgr[15:8];
            px.red_in = pr.bgr[7:0];
            if (pr.typed)
            begin
                want = '0;
                want.point_valid = pr.want_point;
                want.mask_overwrite = pr.want_mask;
                if (pr.want_point)
                begin
                    want.blue_out = px.blue_in;
                    want.green_out = px.green_in;
                    want.red_out = px.red_in;
                end
            end
            else
                want = project_pixel(px);
            send_pixel(px, want);
        end
        pixel_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);

        // A plausible camera: centre of a VGA frame, f about 525 px, pose near identity.
        write_register(REG_CLASS_LABEL, 64'd7);
        write_register(REG_OPTICAL_CENTER, {32'd0, 16'd3840, 16'd5120});
        write_register(REG_INVERSE_FOCAL, {16'd0, 24'd31957, 24'd31957});
        write_register(REG_POSE_ROW_X, pose_word(16384 - $urandom_range(0, 200),
                       $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                       $urandom_range(0, 2000) - 1000));
        write_register(REG_POSE_ROW_Y, pose_word($urandom_range(0, 400) - 200,
                       16384 - $urandom_range(0, 200), $urandom_range(0, 400) - 200,
                       $urandom_range(0, 2000) - 1000));
        write_register(REG_POSE_ROW_Z, pose_word($urandom_range(0, 400) - 200,
                       $urandom_range(0, 400) - 200, 16384 - $urandom_range(0, 200),
                       $urandom_range(0, 2000) - 1000));
        stream_pixels(108);

        // Arbitrary register contents.
        write_register(REG_CLASS_LABEL, 64'($urandom_range(0, 255)));
        write_register(REG_OPTICAL_CENTER, 64'($urandom));
        write_register(REG_INVERSE_FOCAL, {16'd0, 32'($urandom), 16'($urandom)});
        write_register(REG_POSE_ROW_X, {32'($urandom), 32'($urandom)});
        write_register(REG_POSE_ROW_Y, {32'($urandom), 32'($urandom)});
        write_register(REG_POSE_ROW_Z, {32'($urandom), 32'($urandom)});
        stream_pixels(108);

        // All-ones extremes; the x and y rows drive the sums into saturation.
        write_register(REG_CLASS_LABEL, 64'd255);
        write_register(REG_OPTICAL_CENTER, 64'hFFFF_FFFF);
        write_register(REG_INVERSE_FOCAL, 64'hFFFF_FFFF_FFFF);
        write_register(REG_POSE_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
        write_register(REG_POSE_ROW_Y, 64'h8000_8000_8000_8000);
        write_register(REG_POSE_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
        stream_pixels(108);

        // Zero centre, lopsided focal lengths, identity rotation with extreme shifts.
        write_register(REG_CLASS_LABEL, 64'd0);
        write_register(REG_OPTICAL_CENTER, 64'd0);
        write_register(REG_INVERSE_FOCAL, {16'd0, 24'd0, 24'hFF_FFFF});
        write_register(REG_POSE_ROW_X, pose_word(16384, 0, 0, 32767));
        write_register(REG_POSE_ROW_Y, pose_word(0, 16384, 0, -32768));
        write_register(REG_POSE_ROW_Z, pose_word(0, 0, 16384, 0));
        stream_pixels(108);

        // Drain: let any stray beat surface before the verdict.
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
